[src/ape_pkg.sv]
// Shared types, constants and the arctangent table of the active particle Euler step block.
// No dependencies; every other file imports this package.
package ape_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int ATAN_ENTRIES          = 30;
  localparam int ATAN_IDX_W            = 5;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_X       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_HEADING = 2'd3;

  localparam logic [15:0] STEP_SIZE_RST = 16'd4096;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // round(0.2 / (2*pi) * 2^32) and the CORDIC gain 0.60725293 in Q4.30
  localparam logic signed [28:0] TURN_GAIN = 29'sd136713055;
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

  typedef enum logic [1:0] {
    MUL_NOISE,
    MUL_GAIN,
    MUL_COS,
    MUL_SIN
  } ape_mul_sel_t;

  typedef struct packed {
    logic         capture;
    logic         load_start;
    ape_mul_sel_t mul_sel;
    logic         prod_en;
    logic         hdg_en;
    logic         rot_en;
    logic         add_x;
    logic         add_y;
    logic         load_out;
  } ape_cmd_t;

  typedef struct packed {
    logic rot_last;
  } ape_stat_t;

  typedef struct packed {
    logic               op;
    logic signed [15:0] noise;
  } ape_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [31:0] heading;
  } ape_out_t;

  function automatic logic [29:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:    v = 30'd536870912;
      5'd1:    v = 30'd316933406;
      5'd2:    v = 30'd167458907;
      5'd3:    v = 30'd85004756;
      5'd4:    v = 30'd42667331;
      5'd5:    v = 30'd21354465;
      5'd6:    v = 30'd10679838;
      5'd7:    v = 30'd5340245;
      5'd8:    v = 30'd2670163;
      5'd9:    v = 30'd1335087;
      5'd10:   v = 30'd667544;
      5'd11:   v = 30'd333772;
      5'd12:   v = 30'd166886;
      5'd13:   v = 30'd83443;
      5'd14:   v = 30'd41722;
      5'd15:   v = 30'd20861;
      5'd16:   v = 30'd10430;
      5'd17:   v = 30'd5215;
      5'd18:   v = 30'd2608;
      5'd19:   v = 30'd1304;
      5'd20:   v = 30'd652;
      5'd21:   v = 30'd326;
      5'd22:   v = 30'd163;
      5'd23:   v = 30'd81;
      5'd24:   v = 30'd41;
      5'd25:   v = 30'd20;
      5'd26:   v = 30'd10;
      5'd27:   v = 30'd5;
      5'd28:   v = 30'd3;
      5'd29:   v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

[src/ape_ctrl.sv]
// Sequencing controller of the active particle step: handshakes and datapath commands.
// Depends on ape_pkg for the command and status structs.
module ape_ctrl import ape_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      in_op,
  output logic      out_valid,
  input  logic      out_ready,
  output ape_cmd_t  cmd,
  input  ape_stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MP,
    S_MG,
    S_HD,
    S_ROT,
    S_MX,
    S_AX,
    S_AY,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire;
  logic   out_fire;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture    = in_fire;
        cmd.load_start = in_fire && (in_op == OP_LOAD);
        if (in_fire) begin
          state_nxt = (in_op == OP_STEP) ? S_MP : S_OUT;
        end
      end
      S_MP: begin
        cmd.mul_sel = MUL_NOISE;
        cmd.prod_en = 1'b1;
        state_nxt   = S_MG;
      end
      S_MG: begin
        cmd.mul_sel = MUL_GAIN;
        cmd.prod_en = 1'b1;
        state_nxt   = S_HD;
      end
      S_HD: begin
        cmd.hdg_en = 1'b1;
        state_nxt  = S_ROT;
      end
      S_ROT: begin
        cmd.rot_en = 1'b1;
        if (stat.rot_last) begin
          state_nxt = S_MX;
        end
      end
      S_MX: begin
        cmd.mul_sel = MUL_COS;
        cmd.prod_en = 1'b1;
        state_nxt   = S_AX;
      end
      S_AX: begin
        cmd.add_x   = 1'b1;
        cmd.mul_sel = MUL_SIN;
        cmd.prod_en = 1'b1;
        state_nxt   = S_AY;
      end
      S_AY: begin
        cmd.add_y = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_step_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_op == OP_STEP)) |=> (state_r == S_MP))
    else $error("step transaction did not start the noise multiply");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while a transaction waits");

  a_rot_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_ROT) && !stat.rot_last) |=> (state_r == S_ROT))
    else $error("rotation left before the last iteration");

  a_out_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result shown outside the output state");

endmodule

[src/ape_datapath.sv]
// Datapath of the active particle step: config registers, particle state, shared multiplier,
// iterative CORDIC and saturating position update. Depends on ape_pkg.
module ape_datapath import ape_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ape_cmd_t              cmd,
  output ape_stat_t             stat,
  input  ape_in_t               in_data,
  output ape_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ITERS  = (CORDIC_ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_ITERATIONS;
  localparam int ITER_W = $clog2(ITERS);

  logic        [15:0] step_size_r;
  logic signed [31:0] start_x_r;
  logic signed [31:0] start_y_r;
  logic        [31:0] start_heading_r;

  logic signed [31:0] pos_x_r, pos_x_nxt;
  logic signed [31:0] pos_y_r, pos_y_nxt;
  logic        [31:0] heading_r;
  logic signed [15:0] noise_r;

  logic signed [62:0] prod_r, prod_nxt;
  logic signed [33:0] mul_a;
  logic signed [28:0] mul_b;

  logic signed [33:0] cx_r, cy_r, cz_r;
  logic               flip_r;
  logic [ITER_W-1:0]  iter_r;

  logic signed [62:0] rnd_h, rnd_d;
  logic        [31:0] heading_sum;
  logic               flip_new;
  logic signed [33:0] z_init;
  logic signed [33:0] disp;
  logic signed [33:0] cos_v, sin_v;
  logic signed [33:0] dx, dy, at;
  ape_out_t           out_r;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] pos,
                                                 input logic signed [33:0] d);
    logic signed [33:0] r;
    logic signed [31:0] v;
    r = {{2{pos[31]}}, pos} + d;
    if ((r[33:31] == 3'b000) || (r[33:31] == 3'b111)) begin
      v = r[31:0];
    end else if (r[33]) begin
      v = 32'sh8000_0000;
    end else begin
      v = 32'sh7FFF_FFFF;
    end
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r     <= STEP_SIZE_RST;
      start_x_r       <= '0;
      start_y_r       <= '0;
      start_heading_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_STEP_SIZE:     step_size_r     <= cfg_wdata[15:0];
        REG_START_X:       start_x_r       <= cfg_wdata;
        REG_START_Y:       start_y_r       <= cfg_wdata;
        REG_START_HEADING: start_heading_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_NOISE: begin
        mul_a = {{18{noise_r[15]}}, noise_r};
        mul_b = {13'b0, step_size_r};
      end
      MUL_GAIN: begin
        mul_a = {prod_r[32], prod_r[32:0]};
        mul_b = TURN_GAIN;
      end
      MUL_COS: begin
        mul_a = cos_v;
        mul_b = {13'b0, step_size_r};
      end
      MUL_SIN: begin
        mul_a = sin_v;
        mul_b = {13'b0, step_size_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  assign rnd_h       = prod_r + 63'sd8388608;
  assign rnd_d       = prod_r + 63'sd33554432;
  assign heading_sum = heading_r + rnd_h[55:24];
  assign disp        = rnd_d[59:26];
  assign flip_new    = heading_sum[31] ^ heading_sum[30];
  assign z_init      = {{3{heading_sum[30]}}, heading_sum[30:0]};

  assign cos_v = flip_r ? -cx_r : cx_r;
  assign sin_v = flip_r ? -cy_r : cy_r;
  assign dx    = cy_r >>> iter_r;
  assign dy    = cx_r >>> iter_r;
  assign at    = {4'b0, atan_entry(ATAN_IDX_W'(iter_r))};

  assign stat.rot_last = (iter_r == ITER_W'(ITERS - 1));

  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    if (cmd.load_start) begin
      pos_x_nxt = start_x_r;
      pos_y_nxt = start_y_r;
    end else begin
      if (cmd.add_x) begin
        pos_x_nxt = sat_add(pos_x_r, disp);
      end
      if (cmd.add_y) begin
        pos_y_nxt = sat_add(pos_y_r, disp);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      heading_r <= '0;
    end else begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      if (cmd.load_start) begin
        heading_r <= start_heading_r;
      end else if (cmd.hdg_en) begin
        heading_r <= heading_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      noise_r <= in_data.noise;
    end
    if (cmd.prod_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.hdg_en) begin
      cx_r   <= CORDIC_X0;
      cy_r   <= '0;
      cz_r   <= z_init;
      flip_r <= flip_new;
      iter_r <= '0;
    end else if (cmd.rot_en) begin
      if (!cz_r[33]) begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        cz_r <= cz_r - at;
      end else begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        cz_r <= cz_r + at;
      end
      iter_r <= iter_r + 1'b1;
    end
    if (cmd.load_out) begin
      out_r.pos_x   <= pos_x_r;
      out_r.pos_y   <= pos_y_r;
      out_r.heading <= heading_r;
    end
  end

  assign out_data = out_r;

endmodule

[src/active_particle_euler_step.sv]
// Active particle Euler step: a load passes through the output state to a ready result, a step
// through the multiplies, heading update, CORDIC rotation and displacements, its length set by
// the iterative CORDIC that reuses one add/shift unit per iteration and by the single shared
// multiplier, which handles noise times the step size, the turn gain and both displacements in
// turn. One transaction is in flight at a time; a finished result waits in an output register
// while the next transaction is accepted. No clearing pass follows reset.
module active_particle_euler_step import ape_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ape_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ape_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  ape_cmd_t  cmd;
  ape_stat_t stat;

  ape_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_data.op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  ape_datapath #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

endmodule
